@@ rtl/rgbhsl_pkg.sv @@
// Shared constants and types for the RGB to hue, saturation and luma converter.
package rgbhsl_pkg;

    localparam int PIX_W      = 8;
    localparam int SUM_W      = 10;
    localparam int HNUM_W     = 11;
    localparam int LUMA_ACC_W = 15;

    localparam int NUM_W = 19;
    localparam int DEN_W = 11;
    localparam int Q_W   = 8;

    localparam int NSTAGE = 2 + Q_W;

    localparam int LUMA_RECIP  = 5243;
    localparam int LUMA_SHIFT  = 19;
    localparam int LUMA_PROD_W = 28;

    localparam int HUE_SCALE  = 255;
    localparam int SAT_SCALE  = 510;
    localparam int LUMA_ROUND = 50;
    localparam int LUMA_WR    = 30;
    localparam int LUMA_WG    = 59;
    localparam int LUMA_WB    = 11;

    typedef struct packed {
        logic [PIX_W-1:0]      alpha;
        logic [PIX_W-1:0]      chroma;
        logic [PIX_W-1:0]      mn;
        logic [SUM_W-1:0]      sum;
        logic [HNUM_W-1:0]     hue_num;
        logic [LUMA_ACC_W-1:0] luma_acc;
    } prep_t;

    typedef struct packed {
        logic [PIX_W-1:0] alpha;
        logic [PIX_W-1:0] chroma;
        logic [PIX_W-1:0] luma;
    } side_t;

endpackage

@@ rtl/rgbhsl_div.sv @@
// Pipelined restoring divider that produces one quotient bit per stage.
module rgbhsl_div (
    input  logic                          clk,
    input  logic [rgbhsl_pkg::Q_W-1:0]    load,
    input  logic [rgbhsl_pkg::NUM_W-1:0]  num,
    input  logic [rgbhsl_pkg::DEN_W-1:0]  den,
    output logic [rgbhsl_pkg::Q_W-1:0]    quo
);

    logic [rgbhsl_pkg::NUM_W-1:0] rem_reg  [rgbhsl_pkg::Q_W];
    logic [rgbhsl_pkg::NUM_W-1:0] rem_next [rgbhsl_pkg::Q_W];
    logic [rgbhsl_pkg::NUM_W-1:0] rem_src  [rgbhsl_pkg::Q_W];
    logic [rgbhsl_pkg::DEN_W-1:0] den_reg  [rgbhsl_pkg::Q_W];
    logic [rgbhsl_pkg::DEN_W-1:0] den_src  [rgbhsl_pkg::Q_W];
    logic [rgbhsl_pkg::Q_W-1:0]   q_reg    [rgbhsl_pkg::Q_W];
    logic [rgbhsl_pkg::Q_W-1:0]   q_next   [rgbhsl_pkg::Q_W];
    logic [rgbhsl_pkg::Q_W-1:0]   q_src    [rgbhsl_pkg::Q_W];
    logic [rgbhsl_pkg::NUM_W-1:0] trial    [rgbhsl_pkg::Q_W];

    always_comb
    begin
        rem_src[0] = num;
        den_src[0] = den;
        q_src[0]   = '0;
        for (int s = 1; s < rgbhsl_pkg::Q_W; s++)
        begin
            rem_src[s] = rem_reg[s-1];
            den_src[s] = den_reg[s-1];
            q_src[s]   = q_reg[s-1];
        end
        for (int s = 0; s < rgbhsl_pkg::Q_W; s++)
        begin
            trial[s] = rgbhsl_pkg::NUM_W'(den_src[s]) << (rgbhsl_pkg::Q_W - 1 - s);
            if (rem_src[s] >= trial[s])
            begin
                rem_next[s] = rem_src[s] - trial[s];
                q_next[s]   = q_src[s] | (rgbhsl_pkg::Q_W'(1) << (rgbhsl_pkg::Q_W - 1 - s));
            end
            else
            begin
                rem_next[s] = rem_src[s];
                q_next[s]   = q_src[s];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int s = 0; s < rgbhsl_pkg::Q_W; s++)
        begin
            if (load[s])
            begin
                rem_reg[s] <= rem_next[s];
                den_reg[s] <= den_src[s];
                q_reg[s]   <= q_next[s];
            end
        end
    end

    assign quo = q_reg[rgbhsl_pkg::Q_W-1];

endmodule

@@ rtl/rgb_to_hue_saturation_luma.sv @@
// RGBA pixel to hue, saturation, luma, chroma and alpha converter.
// The pipeline has one preparation stage, one scaling stage and eight
// quotient stages of the two pipelined dividers.
// Throughput is one item per cycle; each stage holds its item under stall.
// Reset clears only the stage valid bits, so the pipeline starts empty.
module rgb_to_hue_saturation_luma (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] red,
    input  logic [7:0] green,
    input  logic [7:0] blue,
    input  logic [7:0] alpha,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] hue,
    output logic [7:0] saturation,
    output logic [7:0] luma,
    output logic [7:0] alpha_out,
    output logic [7:0] chroma
);

    logic [rgbhsl_pkg::NSTAGE-1:0] valid_reg;
    logic [rgbhsl_pkg::NSTAGE:0]   rdy;

    rgbhsl_pkg::prep_t prep_reg;
    rgbhsl_pkg::prep_t prep_next;

    logic [rgbhsl_pkg::PIX_W-1:0] mx;
    logic [rgbhsl_pkg::PIX_W-1:0] mn;
    logic [rgbhsl_pkg::PIX_W-1:0] c;

    logic [rgbhsl_pkg::NUM_W-1:0] hue_num_reg;
    logic [rgbhsl_pkg::NUM_W-1:0] hue_num_next;
    logic [rgbhsl_pkg::DEN_W-1:0] hue_den_reg;
    logic [rgbhsl_pkg::DEN_W-1:0] hue_den_next;
    logic [rgbhsl_pkg::NUM_W-1:0] sat_num_reg;
    logic [rgbhsl_pkg::NUM_W-1:0] sat_num_next;
    logic [rgbhsl_pkg::DEN_W-1:0] sat_den_reg;
    logic [rgbhsl_pkg::DEN_W-1:0] sat_den_next;
    logic [rgbhsl_pkg::SUM_W-1:0] sat_diff;
    logic [rgbhsl_pkg::LUMA_PROD_W-1:0] luma_prod;

    rgbhsl_pkg::side_t side_reg [rgbhsl_pkg::NSTAGE-1];
    rgbhsl_pkg::side_t side_next;

    always_comb
    begin
        rdy[rgbhsl_pkg::NSTAGE] = !out_stall;
        for (int s = rgbhsl_pkg::NSTAGE - 1; s >= 0; s--)
        begin
            rdy[s] = !valid_reg[s] || rdy[s+1];
        end
    end

    assign in_stall  = !rdy[0];
    assign out_valid = valid_reg[rgbhsl_pkg::NSTAGE-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (rdy[0])
            begin
                valid_reg[0] <= in_valid;
            end
            for (int s = 1; s < rgbhsl_pkg::NSTAGE; s++)
            begin
                if (rdy[s])
                begin
                    valid_reg[s] <= valid_reg[s-1];
                end
            end
        end
    end

    // Preparation: extremes, chroma, sector numerator and luma accumulation.
    always_comb
    begin
        mx = (red > green) ? red : green;
        mx = (mx > blue) ? mx : blue;
        mn = (red < green) ? red : green;
        mn = (mn < blue) ? mn : blue;
        c  = mx - mn;

        prep_next.alpha  = alpha;
        prep_next.chroma = c;
        prep_next.mn     = mn;
        prep_next.sum    = rgbhsl_pkg::SUM_W'(red) + rgbhsl_pkg::SUM_W'(green)
                         + rgbhsl_pkg::SUM_W'(blue);

        if (mx == red)
        begin
            if (green >= blue)
            begin
                prep_next.hue_num = rgbhsl_pkg::HNUM_W'(green) - rgbhsl_pkg::HNUM_W'(blue);
            end
            else
            begin
                prep_next.hue_num = rgbhsl_pkg::HNUM_W'(c) * rgbhsl_pkg::HNUM_W'(6)
                                  - (rgbhsl_pkg::HNUM_W'(blue) - rgbhsl_pkg::HNUM_W'(green));
            end
        end
        else if (mx == green)
        begin
            prep_next.hue_num = rgbhsl_pkg::HNUM_W'(c) * rgbhsl_pkg::HNUM_W'(2)
                              + rgbhsl_pkg::HNUM_W'(blue) - rgbhsl_pkg::HNUM_W'(red);
        end
        else
        begin
            prep_next.hue_num = rgbhsl_pkg::HNUM_W'(c) * rgbhsl_pkg::HNUM_W'(4)
                              + rgbhsl_pkg::HNUM_W'(red) - rgbhsl_pkg::HNUM_W'(green);
        end

        prep_next.luma_acc =
              rgbhsl_pkg::LUMA_ACC_W'(red)   * rgbhsl_pkg::LUMA_ACC_W'(rgbhsl_pkg::LUMA_WR)
            + rgbhsl_pkg::LUMA_ACC_W'(green) * rgbhsl_pkg::LUMA_ACC_W'(rgbhsl_pkg::LUMA_WG)
            + rgbhsl_pkg::LUMA_ACC_W'(blue)  * rgbhsl_pkg::LUMA_ACC_W'(rgbhsl_pkg::LUMA_WB)
            + rgbhsl_pkg::LUMA_ACC_W'(rgbhsl_pkg::LUMA_ROUND);
    end

    always_ff @(posedge clk)
    begin
        if (rdy[0])
        begin
            prep_reg <= prep_next;
        end
    end

    // Scaling: divider operands, with a unit divisor for grey and black pixels, and the scaled luma.
    always_comb
    begin
        hue_num_next = rgbhsl_pkg::NUM_W'(prep_reg.hue_num)
                         * rgbhsl_pkg::NUM_W'(rgbhsl_pkg::HUE_SCALE)
                     + rgbhsl_pkg::NUM_W'(prep_reg.chroma) * rgbhsl_pkg::NUM_W'(3);
        if (prep_reg.chroma == '0)
        begin
            hue_den_next = rgbhsl_pkg::DEN_W'(1);
        end
        else
        begin
            hue_den_next = rgbhsl_pkg::DEN_W'(prep_reg.chroma) * rgbhsl_pkg::DEN_W'(6);
        end

        sat_diff     = prep_reg.sum - rgbhsl_pkg::SUM_W'(prep_reg.mn) * rgbhsl_pkg::SUM_W'(3);
        sat_num_next = rgbhsl_pkg::NUM_W'(sat_diff) * rgbhsl_pkg::NUM_W'(rgbhsl_pkg::SAT_SCALE)
                     + rgbhsl_pkg::NUM_W'(prep_reg.sum);
        if (prep_reg.sum == '0)
        begin
            sat_den_next = rgbhsl_pkg::DEN_W'(1);
        end
        else
        begin
            sat_den_next = rgbhsl_pkg::DEN_W'(prep_reg.sum) * rgbhsl_pkg::DEN_W'(2);
        end

        luma_prod = rgbhsl_pkg::LUMA_PROD_W'(prep_reg.luma_acc)
                  * rgbhsl_pkg::LUMA_PROD_W'(rgbhsl_pkg::LUMA_RECIP);

        side_next.alpha  = prep_reg.alpha;
        side_next.chroma = prep_reg.chroma;
        side_next.luma   = luma_prod[rgbhsl_pkg::LUMA_SHIFT +: rgbhsl_pkg::PIX_W];
    end

    always_ff @(posedge clk)
    begin
        if (rdy[1])
        begin
            hue_num_reg <= hue_num_next;
            hue_den_reg <= hue_den_next;
            sat_num_reg <= sat_num_next;
            sat_den_reg <= sat_den_next;
            side_reg[0] <= side_next;
        end
        for (int k = 1; k < rgbhsl_pkg::NSTAGE - 1; k++)
        begin
            if (rdy[k+1])
            begin
                side_reg[k] <= side_reg[k-1];
            end
        end
    end

    rgbhsl_div u_hue_div (
        .clk  (clk),
        .load (rdy[2 +: rgbhsl_pkg::Q_W]),
        .num  (hue_num_reg),
        .den  (hue_den_reg),
        .quo  (hue)
    );

    rgbhsl_div u_sat_div (
        .clk  (clk),
        .load (rdy[2 +: rgbhsl_pkg::Q_W]),
        .num  (sat_num_reg),
        .den  (sat_den_reg),
        .quo  (saturation)
    );

    assign luma      = side_reg[rgbhsl_pkg::NSTAGE-2].luma;
    assign alpha_out = side_reg[rgbhsl_pkg::NSTAGE-2].alpha;
    assign chroma    = side_reg[rgbhsl_pkg::NSTAGE-2].chroma;

    a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> valid_reg[0])
        else $error("accepted item did not enter the first stage");

    a_divisor_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg[1] |-> (hue_den_reg != '0 && sat_den_reg != '0))
        else $error("divider operand stage holds a zero divisor");

    a_full_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        (out_stall && (&valid_reg)) |-> in_stall)
        else $error("full pipeline under output stall did not stall the input");

    a_stalled_output_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(hue) && $stable(luma)))
        else $error("stalled result changed");

endmodule
